FILE: sv/tsws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsws_pkg
// Shared types and constants for the token stream word segmenter.
// ----------------------------------------------------------------------------
package tsws_pkg;

  localparam int unsigned TOKEN_W = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned FRAME_W = 16;

  localparam logic [FRAME_W-1:0] FRAME_TOP = 16'hFFFF;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  localparam logic KIND_LETTER = 1'b0;
  localparam logic KIND_WORD   = 1'b1;

  typedef enum logic [1:0] {
    REG_LEXICON_MODE  = 2'd0,
    REG_SILENCE_INDEX = 2'd1,
    REG_BLANK_INDEX   = 2'd2,
    REG_BLANK_PRESENT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic               kind;
    logic [WORD_W-1:0]  value;
    logic [FRAME_W-1:0] begin_frame;
    logic [FRAME_W-1:0] end_frame;
    logic               last;
  } result_t;

endpackage

FILE: sv/token_stream_word_segmenter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_stream_word_segmenter_unit
// Splits a stream of decoded frames into kept letters and words with
// begin and end frame numbers, in lexicon or letter-collapsing mode.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// s_*      | in        | tdata {word_id, token}, tuser first_frame, tlast last_frame
// m_*      | out       | tdata {end_frame, begin_frame, value}, tuser kind, tlast last
// APB      | in/out    | lexicon_mode, silence_index, blank_index, blank_present
//
// One frame is accepted per cycle while s_tready is high; its results are
// written into a 4-entry result queue in the same edge and leave one per
// cycle while m_tready is high. Two-result frames drain one result per cycle,
// so the queue sets the sustained rate; s_tready drops under two free slots.
// Reset (rst, synchronous) clears state, registers and the queue.
// ----------------------------------------------------------------------------
module token_stream_word_segmenter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // token[7:0], word_id[23:8]
  input  logic        s_tuser,   // first_frame
  input  logic        s_tlast,   // last_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // value[15:0], begin_frame[31:16], end_frame[47:32]
  output logic        m_tuser,   // kind
  output logic        m_tlast,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                            lexicon_mode;
  logic [tsws_pkg::TOKEN_W-1:0]    silence_index;
  logic [tsws_pkg::TOKEN_W-1:0]    blank_index;
  logic                            blank_present;

  logic [tsws_pkg::FRAME_W-1:0]    frame_count;
  logic [tsws_pkg::TOKEN_W-1:0]    prior_token;
  logic                            prior_was_blank;
  logic                            word_open;
  logic [tsws_pkg::FRAME_W-1:0]    word_start;

  logic [tsws_pkg::FRAME_W-1:0]    frame_count_next;
  logic                            word_open_next;
  logic [tsws_pkg::FRAME_W-1:0]    word_start_next;

  tsws_pkg::result_t               fifo [tsws_pkg::FIFO_DEPTH];
  logic [tsws_pkg::PTR_W-1:0]      wr_ptr;
  logic [tsws_pkg::PTR_W-1:0]      rd_ptr;
  logic [tsws_pkg::CNT_W-1:0]      count;

  logic                            in_fire;
  logic                            out_fire;
  logic                            cfg_wr;
  tsws_pkg::reg_idx_t              cfg_idx;

  logic [tsws_pkg::TOKEN_W-1:0]    token;
  logic [tsws_pkg::WORD_W-1:0]     word_id;
  logic [tsws_pkg::FRAME_W-1:0]    frame;
  logic                            seq_start;
  logic                            wo;
  logic                            pwb;
  logic                            is_blank;
  logic                            is_sil;
  logic                            letter_frame;
  logic                            keep;
  logic                            wo_kept;
  logic                            close_word;
  tsws_pkg::result_t               res0;
  tsws_pkg::result_t               res1;
  logic [1:0]                      res_n;
  tsws_pkg::result_t               head;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = tsws_pkg::reg_idx_t'(paddr[3:2]);
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign s_tready = count < tsws_pkg::CNT_W'(tsws_pkg::FIFO_DEPTH - 1);
  assign m_tvalid = count != '0;
  assign head     = fifo[rd_ptr];
  assign m_tdata  = {head.end_frame, head.begin_frame, head.value};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  always_comb begin
    unique case (cfg_idx)
      tsws_pkg::REG_LEXICON_MODE:  prdata = {31'd0, lexicon_mode};
      tsws_pkg::REG_SILENCE_INDEX: prdata = {24'd0, silence_index};
      tsws_pkg::REG_BLANK_INDEX:   prdata = {24'd0, blank_index};
      tsws_pkg::REG_BLANK_PRESENT: prdata = {31'd0, blank_present};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lexicon_mode  <= 1'b0;
      silence_index <= '0;
      blank_index   <= '0;
      blank_present <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tsws_pkg::REG_LEXICON_MODE:  lexicon_mode  <= pwdata[0];
        tsws_pkg::REG_SILENCE_INDEX: silence_index <= pwdata[7:0];
        tsws_pkg::REG_BLANK_INDEX:   blank_index   <= pwdata[7:0];
        tsws_pkg::REG_BLANK_PRESENT: blank_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    token        = s_tdata[7:0];
    word_id      = s_tdata[23:8];
    frame        = s_tuser ? '0 : frame_count;
    seq_start    = s_tuser || (frame_count == '0);
    wo           = s_tuser ? 1'b0 : word_open;
    pwb          = s_tuser ? 1'b0 : prior_was_blank;
    is_blank     = blank_present && (token == blank_index);
    is_sil       = token == silence_index;
    letter_frame = !is_sil && !is_blank;
    word_start_next = (letter_frame && !wo) ? frame : word_start;
    frame_count_next = (frame == tsws_pkg::FRAME_TOP) ? tsws_pkg::FRAME_TOP
                                                      : frame + 16'd1;
    keep       = 1'b0;
    wo_kept    = 1'b0;
    close_word = 1'b0;
    res0       = '0;
    res1       = '0;
    res_n      = 2'd0;
    if (lexicon_mode) begin
      wo_kept    = wo || letter_frame;
      close_word = wo_kept && (word_id != '0);
      word_open_next = wo_kept && !close_word;
      res0 = '{kind: tsws_pkg::KIND_WORD, value: word_id, begin_frame: word_start_next,
               end_frame: frame, last: 1'b1};
      res_n = close_word ? 2'd1 : 2'd0;
    end else begin
      keep       = letter_frame && (pwb || seq_start || (prior_token != token));
      wo_kept    = wo || keep;
      close_word = (is_sil || s_tlast) && wo_kept;
      word_open_next = wo_kept && !close_word;
      res1 = '{kind: tsws_pkg::KIND_WORD, value: '0, begin_frame: word_start_next,
               end_frame: frame, last: 1'b1};
      if (keep) begin
        res0 = '{kind: tsws_pkg::KIND_LETTER, value: {8'd0, token},
                 begin_frame: word_start_next, end_frame: frame, last: !close_word};
        res_n = close_word ? 2'd2 : 2'd1;
      end else begin
        res0  = res1;
        res_n = close_word ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count     <= '0;
      prior_token     <= '0;
      prior_was_blank <= 1'b0;
      word_open       <= 1'b0;
      word_start      <= '0;
    end else if (in_fire) begin
      frame_count     <= frame_count_next;
      prior_token     <= token;
      prior_was_blank <= is_blank;
      word_open       <= word_open_next;
      word_start      <= word_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (res_n != 2'd0)) begin
      fifo[wr_ptr] <= res0;
    end
    if (in_fire && (res_n == 2'd2)) begin
      fifo[wr_ptr + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + (in_fire ? res_n : 2'd0);
      rd_ptr <= rd_ptr + {1'b0, out_fire};
      count  <= count + {1'b0, (in_fire ? res_n : 2'd0)} - {2'd0, out_fire};
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tsws_pkg::CNT_W'(tsws_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_first_frame_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser) |=> (frame_count == 16'd1))
    else $error("frame count not restarted by first frame");

  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && !in_fire) |=> $stable(count) && $stable(rd_ptr))
    else $error("stalled result queue changed");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the token stream word segmenter. Frames are fed on
// the input stream in bursts with random gaps. The output stream stalls on a
// pattern of its own. A scoreboard models the segmenter's frame tracking and
// predicts every letter and word item. It checks each item field by field.
// Directed frames cover collapsing, blanks, silence, lexicon words, mode
// changes and back-to-back frames. Random sequences under several
// register settings follow.
// ----------------------------------------------------------------------------

class segment_board;
  bit          lex_mode;
  bit [7:0]    sil_idx;
  bit [7:0]    blank_idx;
  bit          blank_on;
  bit [15:0]   frame_count;
  bit [7:0]    prior_tok;
  bit          prior_blank;
  bit          word_open;
  bit [15:0]   word_start;
  tsws_pkg::result_t expected_units[$];
  int          errors;

  function new();
    lex_mode = 0; sil_idx = 0; blank_idx = 0; blank_on = 0;
    frame_count = 0; prior_tok = 0; prior_blank = 0; word_open = 0; word_start = 0;
    errors = 0;
  endfunction

  function void set_reg(tsws_pkg::reg_idx_t idx, logic [31:0] v);
    case (idx)
      tsws_pkg::REG_LEXICON_MODE:  lex_mode = v[0];
      tsws_pkg::REG_SILENCE_INDEX: sil_idx = v[7:0];
      tsws_pkg::REG_BLANK_INDEX:   blank_idx = v[7:0];
      tsws_pkg::REG_BLANK_PRESENT: blank_on = v[0];
    endcase
  endfunction

  function void check_reg(tsws_pkg::reg_idx_t idx, logic [31:0] got);
    logic [31:0] want;
    case (idx)
      tsws_pkg::REG_LEXICON_MODE:  want = {31'd0, lex_mode};
      tsws_pkg::REG_SILENCE_INDEX: want = {24'd0, sil_idx};
      tsws_pkg::REG_BLANK_INDEX:   want = {24'd0, blank_idx};
      default:                     want = {31'd0, blank_on};
    endcase
    if (got !== want) begin
      $error("%s readback: expected %0h, actual %0h", idx.name(), want, got);
      errors++;
    end
  endfunction

  function void add_unit(logic kind, logic [15:0] value, logic [15:0] b, logic [15:0] e);
    tsws_pkg::result_t r;
    r.kind = kind;
    r.value = value;
    r.begin_frame = b;
    r.end_frame = e;
    r.last = 1'b0;
    expected_units.push_back(r);
  endfunction

  function void note_frame(logic [7:0] tok, logic [15:0] wid, logic first, logic last);
    bit [15:0] frame;
    bit        seq_start;
    bit        blank;
    bit        sil;
    int        n;
    int        tail;
    n = 0;
    if (first) begin
      frame = 0;
      word_open = 0;
      prior_blank = 0;
    end else begin
      frame = frame_count;
    end
    seq_start = first || frame_count == 0;
    blank = blank_on && tok == blank_idx;
    sil = tok == sil_idx;
    if (lex_mode) begin
      if (!word_open && !sil && !blank) begin
        word_start = frame;
        word_open = 1;
      end
      if (word_open && wid != 0) begin
        add_unit(tsws_pkg::KIND_WORD, wid, word_start, frame);
        n++;
        word_open = 0;
      end
    end else begin
      if (!sil && !blank) begin
        if (!word_open) word_start = frame;
        if (prior_blank || seq_start || prior_tok != tok) begin
          word_open = 1;
          add_unit(tsws_pkg::KIND_LETTER, {8'd0, tok}, word_start, frame);
          n++;
        end
      end
      if ((sil || last) && word_open) begin
        add_unit(tsws_pkg::KIND_WORD, 16'd0, word_start, frame);
        n++;
        word_open = 0;
      end
    end
    prior_blank = blank;
    prior_tok = tok;
    frame_count = (frame == tsws_pkg::FRAME_TOP) ? tsws_pkg::FRAME_TOP : frame + 16'd1;
    if (n > 0) begin
      tail = expected_units.size() - 1;
      expected_units[tail].last = 1'b1;
    end
  endfunction

  function void check_result(tsws_pkg::result_t got);
    tsws_pkg::result_t want;
    if (expected_units.size() == 0) begin
      $error("unexpected item: kind %0d value %0h end_frame %0d",
             got.kind, got.value, got.end_frame);
      errors++;
      return;
    end
    want = expected_units.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, got.kind);
      errors++;
    end
    if (got.value !== want.value) begin
      $error("value: expected %0h, actual %0h", want.value, got.value);
      errors++;
    end
    if (got.begin_frame !== want.begin_frame) begin
      $error("begin_frame: expected %0d, actual %0d", want.begin_frame, got.begin_frame);
      errors++;
    end
    if (got.end_frame !== want.end_frame) begin
      $error("end_frame: expected %0d, actual %0d", want.end_frame, got.end_frame);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      errors++;
    end
  endfunction

  function int pending();
    return expected_units.size();
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // token[7:0], word_id[23:8]
  logic        s_tuser = 1'b0;  // first_frame
  logic        s_tlast = 1'b0;  // last_frame
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // value[15:0], begin_frame[31:16], end_frame[47:32]
  logic        m_tuser;         // kind
  logic        m_tlast;         // last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  segment_board sb;
  int  cycles = 0;
  bit  gaps_on = 1;
  int  burst_left = 0;
  bit  offering = 0;
  bit  hold_req = 0;
  int  hold_left = 0;
  int  stall_mode = 0;
  int  rx_tick = 0;

  token_stream_word_segmenter_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin : watch
    tsws_pkg::result_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.value = m_tdata[15:0];
        got.begin_frame = m_tdata[31:16];
        got.end_frame = m_tdata[47:32];
        got.last = m_tlast;
        sb.check_result(got);
      end
      if (s_tvalid && s_tready) sb.note_frame(s_tdata[7:0], s_tdata[23:8], s_tuser, s_tlast);
    end
  end

  // output stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= (rx_tick % 7) < 4;
      endcase
    end
    rx_tick++;
    if (rx_tick % 128 == 0) stall_mode = $urandom_range(0, 3);
  end

  task automatic reg_write(tsws_pkg::reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_reg(idx, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(bit lex, bit [7:0] sil, bit [7:0] blank, bit present);
    reg_write(tsws_pkg::REG_LEXICON_MODE, {31'd0, lex});
    reg_write(tsws_pkg::REG_SILENCE_INDEX, {24'd0, sil});
    reg_write(tsws_pkg::REG_BLANK_INDEX, {24'd0, blank});
    reg_write(tsws_pkg::REG_BLANK_PRESENT, {31'd0, present});
  endtask

  task automatic stop_offer();
    if (offering) begin
      s_tvalid <= 1'b0;
      offering = 0;
    end
  endtask

  task automatic sender_pace();
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 12);
        stop_offer();
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  task automatic push_frame(bit [7:0] tok, bit [15:0] wid, bit first, bit last);
    s_tvalid <= 1'b1;
    s_tdata <= {wid, tok};
    s_tuser <= first;
    s_tlast <= last;
    offering = 1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sender_pace();
  endtask

  task automatic wait_empty();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic drain();
    stop_offer();
    wait_empty();
    repeat (12) @(negedge clk);
  endtask

  task automatic run_random(int n_items, bit pressure);
    int        i;
    int        seq_left;
    int        pick;
    bit [7:0]  tok;
    bit [7:0]  prev;
    bit [15:0] wid;
    bit        first;
    bit        last;
    seq_left = 0;
    prev = 0;
    for (i = 0; i < n_items; i++) begin
      if (seq_left == 0) begin
        seq_left = $urandom_range(2, 20);
        first = ($urandom_range(0, 9) != 0);
      end else begin
        first = ($urandom_range(0, 39) == 0);
      end
      last = (seq_left == 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 29) == 0);
      seq_left--;
      pick = $urandom_range(0, 99);
      if (pick < 20) tok = sb.sil_idx;
      else if (pick < 35) tok = sb.blank_idx;
      else if (pick < 50) tok = prev;
      else if (pick < 90) tok = sb.sil_idx + 8'($urandom_range(1, 6));
      else tok = 8'($urandom);
      if (sb.lex_mode)
        wid = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) : 16'd0;
      else
        wid = 16'($urandom);
      if (pressure && i == 25) hold_req = 1;
      if (pressure && i == 60) begin
        stop_offer();
        @(negedge clk);
        wait_empty();
      end
      push_frame(tok, wid, first, last);
      prev = tok;
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: letter mode, silence 0, no blank; count 0 starts a sequence
    push_frame(8'h41, 16'd0, 0, 0);
    push_frame(8'h41, 16'hFFFF, 0, 0);
    push_frame(8'h00, 16'd0, 0, 0);
    drain();

    set_config(0, 8'd1, 8'd2, 1);
    push_frame(8'd5, 16'd0, 1, 0);
    push_frame(8'd5, 16'd0, 0, 0);
    push_frame(8'd2, 16'd0, 0, 0);
    push_frame(8'd5, 16'd0, 0, 0);
    push_frame(8'd255, 16'd0, 0, 0);
    push_frame(8'd1, 16'd0, 0, 0);
    push_frame(8'd9, 16'd0, 0, 1);
    push_frame(8'd9, 16'd0, 0, 0);
    push_frame(8'd10, 16'd0, 0, 1);
    push_frame(8'd0, 16'hFFFF, 1, 1);
    drain();

    // silence and blank on the same index
    set_config(0, 8'd3, 8'd3, 1);
    push_frame(8'd3, 16'd0, 1, 0);
    push_frame(8'd4, 16'd0, 0, 0);
    push_frame(8'd3, 16'd0, 0, 0);
    drain();

    set_config(1, 8'd0, 8'd255, 1);
    push_frame(8'd0, 16'd0, 1, 0);
    push_frame(8'd255, 16'd40, 0, 0);
    push_frame(8'd10, 16'd0, 0, 0);
    push_frame(8'd11, 16'hFFFF, 0, 0);
    push_frame(8'd12, 16'd7, 0, 1);
    push_frame(8'd13, 16'd0, 0, 1);
    push_frame(8'd14, 16'd1, 0, 0);
    push_frame(8'd20, 16'd0, 0, 0);
    drain();

    // switch to letter mode with a lexicon word still open
    reg_write(tsws_pkg::REG_LEXICON_MODE, 32'd0);
    push_frame(8'd20, 16'd0, 0, 0);
    push_frame(8'd0, 16'd0, 0, 0);
    drain();

    // back-to-back frames with no gaps
    set_config(0, 8'd0, 8'd0, 0);
    gaps_on = 0;
    push_frame(8'd0, 16'($urandom), 1, 0);
    repeat (20) push_frame(8'($urandom_range(0, 3)), 16'($urandom), 0, 0);
    gaps_on = 1;
    push_frame(8'h30, 16'd0, 0, 0);
    push_frame(8'h31, 16'd0, 0, 0);
    push_frame(8'h31, 16'd0, 0, 0);
    push_frame(8'd0, 16'd0, 0, 0);
    push_frame(8'h32, 16'd0, 0, 1);
    drain();

    set_config(1, 8'd255, 8'd0, 1);
    run_random(80, 0);
    drain();
    set_config(0, 8'd0, 8'd255, 0);
    run_random(80, 1);
    drain();
    set_config(0, 8'($urandom), 8'($urandom), 1);
    run_random(80, 0);
    drain();
    set_config(1, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
    run_random(80, 0);
    drain();
    set_config(0, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
    run_random(40, 0);
    drain();

    if (sb.errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end
endmodule
